// ----- rtl/core/dprf_pkg.sv -----
package dprf_pkg;

  // Fixed limits of the splitter.
  localparam int MAX_PARTS           = 4;
  localparam int MAX_BUFFER_BYTES    = 65536;
  localparam int MAX_DELIMITER_BYTES = 8;

  // Field widths.
  localparam int POS_W  = 17;
  localparam int PART_W = 2;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;
  localparam int ADDR_W = 4;

  // Result queue sizing; one input byte can produce two results.
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // Register indexes, taken from the 8-byte aligned address.
  localparam logic REG_DELIM_BYTES  = 1'b0;
  localparam logic REG_DELIM_LENGTH = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } byte_item_t;

  typedef struct packed {
    logic [PART_W-1:0] part_number;
    logic [POS_W-1:0]  range_start;
    logic [POS_W-1:0]  range_end;
    logic              final_part;
    logic              length_overflow;
  } part_item_t;

  // Results handed from the compute stage to the result queue.
  typedef struct packed {
    logic [1:0] count;
    part_item_t first;
    part_item_t second;
  } push_t;

endpackage

// ----- rtl/core/dprf_cfg.sv -----
module dprf_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dprf_pkg::ADDR_W-1:0]  paddr,
  input  logic [dprf_pkg::DATA_W-1:0]  pwdata,
  output logic [dprf_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [63:0]                  delimiter_bytes,
  output logic [dprf_pkg::LEN_W-1:0]   delimiter_length,
  output logic                         cfg_write
);

  logic reg_sel;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_bytes  <= '0;
      delimiter_length <= dprf_pkg::LEN_W'(1);
    end else if (cfg_write) begin
      unique case (reg_sel)
        dprf_pkg::REG_DELIM_BYTES:  delimiter_bytes  <= pwdata;
        dprf_pkg::REG_DELIM_LENGTH: delimiter_length <= pwdata[dprf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dprf_pkg::REG_DELIM_BYTES:  prdata = delimiter_bytes;
      dprf_pkg::REG_DELIM_LENGTH: prdata = {{(dprf_pkg::DATA_W-dprf_pkg::LEN_W){1'b0}},
                                            delimiter_length};
      default:                    prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/dprf_core.sv -----
module dprf_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_stall,
  input  dprf_pkg::byte_item_t        byte_data,
  input  logic                        room,
  input  logic [63:0]                 delimiter_bytes,
  input  logic [dprf_pkg::LEN_W-1:0]  delimiter_length,
  input  logic                        cfg_write,
  output dprf_pkg::push_t             push
);

  localparam logic [dprf_pkg::POS_W-1:0] POS_LIMIT =
    dprf_pkg::POS_W'(dprf_pkg::MAX_BUFFER_BYTES);
  localparam logic [dprf_pkg::LEN_W-1:0] LEN_MAX =
    dprf_pkg::LEN_W'(dprf_pkg::MAX_DELIMITER_BYTES);
  localparam logic [dprf_pkg::PART_W:0] LAST_PART =
    (dprf_pkg::PART_W+1)'(dprf_pkg::MAX_PARTS - 1);

  // Input register.
  logic                 in_q_valid;
  dprf_pkg::byte_item_t in_q;
  logic                 advance;

  // Scan state.
  logic [dprf_pkg::LEN_W-1:0]  match_count, match_count_next;
  logic [dprf_pkg::POS_W-1:0]  byte_position, byte_position_next;
  logic [dprf_pkg::POS_W-1:0]  current_part_start, current_part_start_next;
  logic [dprf_pkg::PART_W-1:0] current_part_number, current_part_number_next;
  logic                        overflow_seen, overflow_seen_next;

  logic [7:0][7:0]             delim;
  logic [dprf_pkg::LEN_W-1:0]  dlen;
  logic                        at_limit;
  logic                        ovf;
  logic [dprf_pkg::POS_W-1:0]  pos;
  logic [dprf_pkg::POS_W-1:0]  pos_end;
  logic                        match_enable;
  logic [dprf_pkg::LEN_W-1:0]  mc_base;
  logic [dprf_pkg::LEN_W-1:0]  mc_hit;
  logic                        matched;
  logic [dprf_pkg::PART_W-1:0] part_after;
  logic [dprf_pkg::POS_W-1:0]  start_after;
  dprf_pkg::part_item_t        res_delim;
  dprf_pkg::part_item_t        res_end;

  assign advance    = in_q_valid && room;
  assign byte_stall = in_q_valid && !room;
  assign delim      = delimiter_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_q <= byte_data;
    end
  end

  always_comb begin
    if (delimiter_length == '0) begin
      dlen = dprf_pkg::LEN_W'(1);
    end else if (delimiter_length > LEN_MAX) begin
      dlen = LEN_MAX;
    end else begin
      dlen = delimiter_length;
    end

    // Past the position range the offset saturates at the last byte.
    at_limit = byte_position >= POS_LIMIT;
    ovf      = overflow_seen || at_limit;
    pos      = at_limit ? POS_LIMIT - dprf_pkg::POS_W'(1) : byte_position;
    pos_end  = pos + dprf_pkg::POS_W'(1);
    byte_position_next = at_limit ? POS_LIMIT : byte_position + dprf_pkg::POS_W'(1);

    // The last permitted part takes no delimiters.
    match_enable = !ovf &&
                   ((dprf_pkg::PART_W+1)'(current_part_number) < LAST_PART);

    mc_base = (match_count >= dlen) ? '0 : match_count;
    if (in_q.data_byte == delim[mc_base[2:0]]) begin
      mc_hit = mc_base + dprf_pkg::LEN_W'(1);
    end else if (in_q.data_byte == delim[0]) begin
      mc_hit = dprf_pkg::LEN_W'(1);
    end else begin
      mc_hit = '0;
    end
    matched = match_enable && (mc_hit == dlen);

    res_delim.part_number     = current_part_number;
    res_delim.range_start     = current_part_start;
    res_delim.range_end       = pos_end - dprf_pkg::POS_W'(dlen);
    res_delim.final_part      = 1'b0;
    res_delim.length_overflow = ovf;

    part_after  = matched ? current_part_number + dprf_pkg::PART_W'(1)
                          : current_part_number;
    start_after = matched ? pos_end : current_part_start;

    res_end.part_number     = part_after;
    res_end.range_start     = start_after;
    res_end.range_end       = pos_end;
    res_end.final_part      = 1'b1;
    res_end.length_overflow = ovf;

    push.first  = matched ? res_delim : res_end;
    push.second = res_end;
    if (!advance) begin
      push.count = 2'd0;
    end else begin
      push.count = {1'b0, matched} + {1'b0, in_q.end_of_buffer};
    end

    if (in_q.end_of_buffer) begin
      match_count_next         = '0;
      byte_position_next       = '0;
      current_part_start_next  = '0;
      current_part_number_next = '0;
      overflow_seen_next       = 1'b0;
    end else begin
      match_count_next         = (matched || !match_enable) ? '0 : mc_hit;
      current_part_start_next  = start_after;
      current_part_number_next = part_after;
      overflow_seen_next       = ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_count         <= '0;
      byte_position       <= '0;
      current_part_start  <= '0;
      current_part_number <= '0;
      overflow_seen       <= 1'b0;
    end else begin
      if (advance) begin
        byte_position       <= byte_position_next;
        current_part_start  <= current_part_start_next;
        current_part_number <= current_part_number_next;
        overflow_seen       <= overflow_seen_next;
      end
      if (cfg_write) begin
        match_count <= '0;
      end else if (advance) begin
        match_count <= match_count_next;
      end
    end
  end

endmodule

// ----- rtl/core/dprf_outq.sv -----
module dprf_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  dprf_pkg::push_t       push,
  output logic                  room,
  output logic                  part_valid,
  input  logic                  part_stall,
  output dprf_pkg::part_item_t  part_data
);

  dprf_pkg::part_item_t               entries [dprf_pkg::OUTQ_DEPTH];
  logic [dprf_pkg::OUTQ_PTR_W-1:0]    wr_ptr;
  logic [dprf_pkg::OUTQ_PTR_W-1:0]    rd_ptr;
  logic [dprf_pkg::OUTQ_CNT_W-1:0]    count;
  logic [dprf_pkg::OUTQ_PTR_W-1:0]    wr_ptr_second;
  logic                               pop;

  assign part_valid    = count != '0;
  assign part_data     = entries[rd_ptr];
  assign pop           = part_valid && !part_stall;
  assign room          = count <= dprf_pkg::OUTQ_CNT_W'(dprf_pkg::OUTQ_DEPTH - 2);
  assign wr_ptr_second = wr_ptr + dprf_pkg::OUTQ_PTR_W'(1);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_second] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + dprf_pkg::OUTQ_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + dprf_pkg::OUTQ_PTR_W'(1);
      end
      count <= count + dprf_pkg::OUTQ_CNT_W'(push.count)
                     - dprf_pkg::OUTQ_CNT_W'(pop);
    end
  end

endmodule

// ----- rtl/core/delimited_part_range_finder.sv -----
// A transferred byte is captured in the input register, then scanned and its results written into the result
// queue, whose head entry drives the output.
// Throughput: one byte per cycle; a byte that closes two parts needs two result transfers,
// and the four-entry result queue stalls input while fewer than two entries are free.
// Reset (rst, synchronous, active high) empties the input register and the result queue,
// clears the scan state, and sets the delimiter to one zero byte.
module delimited_part_range_finder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         byte_valid,
  output logic                         byte_stall,
  input  dprf_pkg::byte_item_t         byte_data,
  output logic                         part_valid,
  input  logic                         part_stall,
  output dprf_pkg::part_item_t         part_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dprf_pkg::ADDR_W-1:0]  paddr,
  input  logic [dprf_pkg::DATA_W-1:0]  pwdata,
  output logic [dprf_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  // The block has three parts. The register file holds the delimiter bytes
  // (address 0) and the delimiter length (address 8). The core registers each
  // byte transfer, then compares it against the delimiter byte picked by the
  // match count and, once the queue has room, updates the position and part
  // state, producing zero, one or two part ranges. Those ranges go into a small
  // queue that feeds the output channel one transfer at a time, so a stalled
  // result never blocks the byte that follows it unless the queue is nearly full.

  logic [63:0]                 delimiter_bytes;
  logic [dprf_pkg::LEN_W-1:0]  delimiter_length;
  logic                        cfg_write;
  logic                        room;
  dprf_pkg::push_t             push;

  dprf_cfg u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .delimiter_bytes  (delimiter_bytes),
    .delimiter_length (delimiter_length),
    .cfg_write        (cfg_write)
  );

  // Any register write also restarts the match count.
  dprf_core u_core (
    .clk              (clk),
    .rst              (rst),
    .byte_valid       (byte_valid),
    .byte_stall       (byte_stall),
    .byte_data        (byte_data),
    .room             (room),
    .delimiter_bytes  (delimiter_bytes),
    .delimiter_length (delimiter_length),
    .cfg_write        (cfg_write),
    .push             (push)
  );

  dprf_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .part_valid (part_valid),
    .part_stall (part_stall),
    .part_data  (part_data)
  );

endmodule
